FILE: src/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants for the tenant / top-K flow statistics
// Payload words, slot outcome codes, drop reasons and the slot cell record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tts_pkg;

  localparam int unsigned TenantsDefault = 64;
  localparam int unsigned TopkDefault    = 8;
  localparam int unsigned KeyBitsDefault = 104;

  localparam int unsigned KeyW     = 104;
  localparam int unsigned KeyLowW  = 64;
  localparam int unsigned KeyHighW = 40;
  localparam int unsigned CntW     = 64;
  localparam int unsigned LenW     = 16;
  localparam int unsigned SlotIdxW = 6;
  localparam int unsigned NumDrop  = 3;

  typedef enum logic [2:0] {
    OUT_INSERTED = 3'd0,
    OUT_HIT      = 3'd1,
    OUT_REPLACED = 3'd2,
    OUT_REJECTED = 3'd3,
    OUT_DROP     = 3'd4
  } slot_outcome_e;

  typedef enum logic [1:0] {
    DROP_PARSE     = 2'd0,
    DROP_UNMATCHED = 2'd1,
    DROP_RATE      = 2'd2,
    DROP_OTHER     = 2'd3
  } drop_reason_e;

  typedef enum logic [0:0] {
    FUNC_PKT  = 1'b0,
    FUNC_DROP = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_COMMIT = 2'd2,
    ST_OUT    = 2'd3
  } state_e;

  typedef struct packed {
    logic [0:0]  func;
    logic [7:0]  tenant;
    logic [15:0] pkt_length;
    logic [63:0] flow_key_low;
    logic [39:0] flow_key_high;
    logic [1:0]  drop_reason;
  } in_word_t;

  typedef struct packed {
    logic [0:0]  tenant_counted;
    logic [63:0] tenant_pkt_total;
    logic [63:0] tenant_byte_total;
    logic [5:0]  slot_index;
    logic [2:0]  slot_outcome;
    logic [63:0] slot_pkt_total;
    logic [63:0] slot_byte_total;
    logic [63:0] drop_total;
  } out_word_t;

  // running scan record handed from cell to cell
  typedef struct packed {
    logic            found;     // empty or matching slot seen
    logic            hit;       // found slot was a key match
    logic [5:0]      f_idx;
    logic [63:0]     f_pkt;
    logic [63:0]     f_byte;
    logic [5:0]      m_idx;     // minimum packet count so far
    logic [63:0]     m_pkt;
    logic [63:0]     m_byte;
  } scan_t;

  // write command broadcast to the cells
  typedef struct packed {
    logic        wr;
    logic [5:0]  idx;
    logic        fresh;   // load key, pkt=1, bytes=len; else add
    logic [15:0] len;
  } slot_cmd_t;

endpackage

FILE: src/tenant_and_topk_flow_stats.sv
// ----------------------------------------------------------------------------
// tenant_and_topk_flow_stats: per-tenant counters, drop counters, top-K flows
// Top level: handshake control, tenant counter memories and slot cell row.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid_i/in_ready_o/in_word_i carry one event word (packet or drop).
//   out_valid_o/out_ready_i/out_word_o return exactly one result per event.
//   One event is in flight at a time. After acceptance the SCAN state does a
//   tenant memory read and the slot scan, then the COMMIT state writes tenant
//   and slot state and loads the result register, and OUT raises out_valid_o.
//   in_ready_o rises again the cycle after the result is taken, so a new
//   event is accepted only once the previous result is taken. The slot
//   scan runs combinationally through the row of slot cells; the tenant
//   counters sit in a memory with a registered read port.
//   At reset all counters and slots clear; the tenant memory is then swept
//   to zero, one entry a cycle, with in_ready_o low.
//   A stalled receiver holds the result; in_ready_o stays low meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tenant_and_topk_flow_stats
  import tts_pkg::*;
#(
  parameter int unsigned TENANTS  = TenantsDefault,
  parameter int unsigned TOPK     = TopkDefault,
  parameter int unsigned KEY_BITS = KeyBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int unsigned TidW = (TENANTS > 1) ? $clog2(TENANTS) : 1;
  localparam int unsigned ClrW = $clog2(TENANTS + 1);

  state_e          state_q, state_d;
  in_word_t        ev_q;
  logic [KeyW-1:0] key_q;
  logic [ClrW-1:0] clr_q;
  logic            clr_done;
  out_word_t       res_q, res_d;

  logic [CntW-1:0] t_pkt_mem [TENANTS];
  logic [CntW-1:0] t_byte_mem [TENANTS];
  logic [CntW-1:0] t_pkt_rd_q, t_byte_rd_q;
  logic [CntW-1:0] drop_q [NumDrop];
  logic            t_ok;
  logic [TidW-1:0] tid;
  logic            accept;

  scan_t     chain [TOPK+1];
  scan_t     scan_q;
  slot_cmd_t cmd;
  logic [KeyW-1:0] key_in;

  assign clr_done   = (clr_q == ClrW'(TENANTS));
  assign in_ready_o = (state_q == ST_IDLE) && clr_done;
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_word_o  = res_q;
  assign tid  = TidW'(ev_q.tenant);
  assign t_ok = ({24'd0, ev_q.tenant} < 32'(TENANTS));

  always_comb begin
    key_in = {in_word_i.flow_key_high, in_word_i.flow_key_low};
    for (int b = 0; b < KeyW; b++) begin
      if (b >= KEY_BITS) key_in[b] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      clr_q   <= '0;
      for (int i = 0; i < NumDrop; i++) drop_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (!clr_done) clr_q <= clr_q + ClrW'(1);
      if (state_q == ST_COMMIT && ev_q.func == FUNC_DROP
          && ev_q.drop_reason != DROP_OTHER) begin
        drop_q[ev_q.drop_reason] <= drop_q[ev_q.drop_reason] + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_q  <= in_word_i;
      key_q <= key_in;
    end
    if (state_q == ST_SCAN) scan_q <= chain[TOPK];
    if (state_q == ST_COMMIT) res_q <= res_d;
  end

  // tenant memories: registered read, one write port shared with the sweep
  always_ff @(posedge clk_i) begin
    t_pkt_rd_q  <= t_pkt_mem[tid];
    t_byte_rd_q <= t_byte_mem[tid];
    if (!clr_done) begin
      t_pkt_mem[clr_q[TidW-1:0]]  <= '0;
      t_byte_mem[clr_q[TidW-1:0]] <= '0;
    end else if (state_q == ST_COMMIT && ev_q.func == FUNC_PKT && t_ok) begin
      t_pkt_mem[tid]  <= t_pkt_rd_q + CntW'(1);
      t_byte_mem[tid] <= t_byte_rd_q + CntW'(ev_q.pkt_length);
    end
  end

  assign chain[0] = '0;
  for (genvar g = 0; g < TOPK; g++) begin : g_cell
    tts_cell #(.Index(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key_q),
      .scan_i (chain[g]),
      .cmd_i  (cmd),
      .scan_o (chain[g+1])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_SCAN;
      ST_SCAN:   state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_OUT;
      ST_OUT:    if (out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    cmd.len = ev_q.pkt_length;
    res_d   = '0;
    if (ev_q.func == FUNC_DROP) begin
      res_d.slot_outcome = OUT_DROP;
      if (ev_q.drop_reason != DROP_OTHER)
        res_d.drop_total = drop_q[ev_q.drop_reason] + CntW'(1);
    end else begin
      if (t_ok) begin
        res_d.tenant_counted    = 1'b1;
        res_d.tenant_pkt_total  = t_pkt_rd_q + CntW'(1);
        res_d.tenant_byte_total = t_byte_rd_q + CntW'(ev_q.pkt_length);
      end
      if (scan_q.found) begin
        cmd.wr = 1'b1;
        cmd.idx = scan_q.f_idx;
        res_d.slot_index = scan_q.f_idx;
        if (scan_q.hit) begin
          cmd.fresh = 1'b0;
          res_d.slot_outcome    = OUT_HIT;
          res_d.slot_pkt_total  = scan_q.f_pkt + CntW'(1);
          res_d.slot_byte_total = scan_q.f_byte + CntW'(ev_q.pkt_length);
        end else begin
          cmd.fresh = 1'b1;
          res_d.slot_outcome    = OUT_INSERTED;
          res_d.slot_pkt_total  = CntW'(1);
          res_d.slot_byte_total = CntW'(ev_q.pkt_length);
        end
      end else begin
        res_d.slot_index = scan_q.m_idx;
        if (CntW'(ev_q.pkt_length) > scan_q.m_byte) begin
          cmd.wr = 1'b1;
          cmd.fresh = 1'b1;
          cmd.idx = scan_q.m_idx;
          res_d.slot_outcome    = OUT_REPLACED;
          res_d.slot_pkt_total  = CntW'(1);
          res_d.slot_byte_total = CntW'(ev_q.pkt_length);
        end else begin
          res_d.slot_outcome    = OUT_REJECTED;
          res_d.slot_pkt_total  = scan_q.m_pkt;
          res_d.slot_byte_total = scan_q.m_byte;
        end
      end
    end
    if (state_q != ST_COMMIT || ev_q.func == FUNC_DROP) cmd.wr = 1'b0;
  end

endmodule

FILE: src/tts_cell.sv
// ----------------------------------------------------------------------------
// tts_cell: one top-K slot
// Holds key and counters, compares against the key and folds into the scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tts_cell
  import tts_pkg::*;
#(
  parameter int unsigned Index = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [KeyW-1:0]  key_i,
  input  scan_t            scan_i,
  input  slot_cmd_t        cmd_i,
  output scan_t            scan_o
);

  logic [KeyW-1:0] key_q;
  logic [CntW-1:0] pkt_q, byte_q;
  logic            match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      pkt_q  <= '0;
      byte_q <= '0;
    end else if (cmd_i.wr && cmd_i.idx == SlotIdxW'(Index)) begin
      if (cmd_i.fresh) begin
        key_q  <= key_i;
        pkt_q  <= CntW'(1);
        byte_q <= CntW'(cmd_i.len);
      end else begin
        pkt_q  <= pkt_q + CntW'(1);
        byte_q <= byte_q + CntW'(cmd_i.len);
      end
    end
  end

  assign match = (key_q == key_i);

  always_comb begin
    scan_o = scan_i;
    if (!scan_i.found && (pkt_q == '0 || match)) begin
      scan_o.found  = 1'b1;
      scan_o.hit    = (pkt_q != '0);
      scan_o.f_idx  = SlotIdxW'(Index);
      scan_o.f_pkt  = pkt_q;
      scan_o.f_byte = byte_q;
    end
    if (Index == 0 || pkt_q < scan_i.m_pkt) begin
      scan_o.m_idx  = SlotIdxW'(Index);
      scan_o.m_pkt  = pkt_q;
      scan_o.m_byte = byte_q;
    end
  end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: tenant_and_topk_flow_stats
// Drives packet and drop words through a bursty sender, with a stalling
// receiver. A local model of tenant, drop and top-K state predicts each
// result word, and every output word is compared with it as a whole.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import tts_pkg::*;

  localparam int NTen = 64;
  localparam int NSlot = 8;
  localparam int CycleLimit = 400000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  tenant_and_topk_flow_stats uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_word_o(out_word_o)
  );

  // predictor state
  logic [63:0] ten_pkts [NTen];
  logic [63:0] ten_bytes [NTen];
  logic [63:0] drops [NumDrop];
  logic [63:0] key_lo [NSlot];
  logic [39:0] key_hi [NSlot];
  logic [63:0] flow_pkts [NSlot];
  logic [63:0] flow_bytes [NSlot];

  out_word_t pending_q[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // receiver stall pattern: phases of always-ready and random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if ((cycles / 500) % 3 == 0) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic out_word_t predict_stats(in_word_t w);
    out_word_t r;
    int idx;
    logic done;
    r = '0;
    if (w.func == FUNC_DROP) begin
      r.slot_outcome = OUT_DROP;
      if (w.drop_reason != DROP_OTHER) begin
        drops[w.drop_reason] = drops[w.drop_reason] + 1;
        r.drop_total = drops[w.drop_reason];
      end
      return r;
    end
    if (w.tenant < NTen) begin
      ten_pkts[w.tenant] = ten_pkts[w.tenant] + 1;
      ten_bytes[w.tenant] = ten_bytes[w.tenant] + 64'(w.pkt_length);
      r.tenant_counted = 1'b1;
      r.tenant_pkt_total = ten_pkts[w.tenant];
      r.tenant_byte_total = ten_bytes[w.tenant];
    end
    done = 1'b0;
    idx = 0;
    for (int i = 0; i < NSlot && !done; i++) begin
      if (flow_pkts[i] == 0) begin
        key_lo[i] = w.flow_key_low;
        key_hi[i] = w.flow_key_high;
        flow_pkts[i] = 1;
        flow_bytes[i] = 64'(w.pkt_length);
        idx = i;
        r.slot_outcome = OUT_INSERTED;
        done = 1'b1;
      end else if (key_lo[i] == w.flow_key_low && key_hi[i] == w.flow_key_high) begin
        flow_pkts[i] = flow_pkts[i] + 1;
        flow_bytes[i] = flow_bytes[i] + 64'(w.pkt_length);
        idx = i;
        r.slot_outcome = OUT_HIT;
        done = 1'b1;
      end
    end
    if (!done) begin
      for (int i = 1; i < NSlot; i++)
        if (flow_pkts[i] < flow_pkts[idx]) idx = i;
      if (64'(w.pkt_length) > flow_bytes[idx]) begin
        key_lo[idx] = w.flow_key_low;
        key_hi[idx] = w.flow_key_high;
        flow_pkts[idx] = 1;
        flow_bytes[idx] = 64'(w.pkt_length);
        r.slot_outcome = OUT_REPLACED;
      end else begin
        r.slot_outcome = OUT_REJECTED;
      end
    end
    r.slot_index = 6'(idx);
    r.slot_pkt_total = flow_pkts[idx];
    r.slot_byte_total = flow_bytes[idx];
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", out_word_o);
      end else begin
        exp_w = pending_q.pop_front();
        if (out_word_o !== exp_w) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp cnt=%0d tp=%0d tb=%0d idx=%0d oc=%0d sp=%0d sb=%0d dr=%0d",
                     exp_w.tenant_counted, exp_w.tenant_pkt_total, exp_w.tenant_byte_total,
                     exp_w.slot_index, exp_w.slot_outcome, exp_w.slot_pkt_total,
                     exp_w.slot_byte_total, exp_w.drop_total);
            $display("          got cnt=%0d tp=%0d tb=%0d idx=%0d oc=%0d sp=%0d sb=%0d dr=%0d",
                     out_word_o.tenant_counted, out_word_o.tenant_pkt_total,
                     out_word_o.tenant_byte_total, out_word_o.slot_index,
                     out_word_o.slot_outcome, out_word_o.slot_pkt_total,
                     out_word_o.slot_byte_total, out_word_o.drop_total);
          end
        end
      end
    end
  end

  // send one word, idling in bursts; valid stays up within a burst
  task automatic send_word(in_word_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_q.push_back(predict_stats(w));
  endtask

  task automatic idle_sender();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic in_word_t pkt_word(logic [7:0] tid, logic [15:0] len,
                                        logic [63:0] klo, logic [39:0] khi);
    in_word_t w;
    w = '0;
    w.func = FUNC_PKT;
    w.tenant = tid;
    w.pkt_length = len;
    w.flow_key_low = klo;
    w.flow_key_high = khi;
    w.drop_reason = 2'($urandom_range(0, 3));
    return w;
  endfunction

  function automatic in_word_t drop_word(drop_reason_e why);
    in_word_t w;
    w = '0;
    w.func = FUNC_DROP;
    w.tenant = 8'($urandom);
    w.pkt_length = 16'($urandom);
    w.flow_key_low = {$urandom, $urandom};
    w.flow_key_high = {8'($urandom), $urandom};
    w.drop_reason = why;
    return w;
  endfunction

  task automatic wait_drained();
    idle_sender();
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // extremes, every outcome, tenant out of range, every drop reason
  task automatic test_directed();
    send_word(pkt_word(8'd0, 16'd0, 64'd0, 40'd0));
    send_word(pkt_word(8'd63, 16'hFFFF, '1, '1));
    send_word(pkt_word(8'd64, 16'd10, '1, '1));
    send_word(pkt_word(8'd255, 16'd1, 64'd0, 40'd0));
    for (int i = 2; i < NSlot; i++)
      send_word(pkt_word(8'(i), 16'(100 * i), 64'(i), 40'(i)));
    // table full: small packet not admitted, large one replaces the minimum
    send_word(pkt_word(8'd5, 16'd1, 64'h1234, 40'h55));
    send_word(pkt_word(8'd5, 16'hFFFF, 64'h1234, 40'h55));
    send_word(pkt_word(8'd5, 16'd3, 64'h1234, 40'h55));
    // key differs only in high word
    send_word(pkt_word(8'd7, 16'd9, 64'h1234, 40'h56));
    send_word(drop_word(DROP_PARSE));
    send_word(drop_word(DROP_UNMATCHED));
    send_word(drop_word(DROP_RATE));
    send_word(drop_word(DROP_OTHER));
    send_word(drop_word(DROP_RATE));
  endtask

  // random traffic, mostly recurring keys from a small pool
  task automatic test_random(int n);
    logic [63:0] pool_lo [12];
    logic [39:0] pool_hi [12];
    int k;
    for (int i = 0; i < 12; i++) begin
      pool_lo[i] = {$urandom, $urandom};
      pool_hi[i] = {8'($urandom), $urandom};
    end
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 11);
      case ($urandom_range(0, 9))
        0: send_word(drop_word(drop_reason_e'($urandom_range(0, 3))));
        1: send_word(pkt_word(8'($urandom), 16'($urandom), {$urandom, $urandom},
                              {8'($urandom), $urandom}));
        default: send_word(pkt_word(8'($urandom_range(0, 70)),
                                    ($urandom_range(0, 1) ? 16'($urandom) :
                                     16'($urandom_range(0, 300))),
                                    pool_lo[k], pool_hi[k]));
      endcase
      if (i == n / 2) wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < NTen; i++) begin
      ten_pkts[i] = '0;
      ten_bytes[i] = '0;
    end
    for (int i = 0; i < NumDrop; i++) drops[i] = '0;
    for (int i = 0; i < NSlot; i++) begin
      key_lo[i] = '0;
      key_hi[i] = '0;
      flow_pkts[i] = '0;
      flow_bytes[i] = '0;
    end
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_random(400);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
src/tts_pkg.sv
src/tts_cell.sv
src/tenant_and_topk_flow_stats.sv
sim/testbench.sv
